FILE: rtl/rcs_pkg.sv
`timescale 1ns / 1ps
// rcs_pkg: shared types and fixed field widths for the rank count sorter
package rcs_pkg;

    localparam int VAL_W     = 16;
    localparam int IDX_OUT_W = 4;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    // sequencer commands to the scan engine and the result store
    typedef struct packed {
        logic scan_start;
        logic emit_en;
    } t_seq_ctl;

endpackage

FILE: rtl/rcs_rank_engine.sv
`timescale 1ns / 1ps
// rcs_rank_engine: value memory and the shared compare pipeline that builds rank counts
module rcs_rank_engine #(
    parameter int MAX_ITEMS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rcs_pkg::t_seq_ctl                 i_ctl,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]    i_n,
    input  logic                              i_load_we,
    input  logic [$clog2(MAX_ITEMS)-1:0]      i_load_addr,
    input  logic [rcs_pkg::VAL_W-1:0]         i_load_data,
    output logic                              o_wr_valid,
    output logic [$clog2(MAX_ITEMS)-1:0]      o_wr_addr,
    output logic [rcs_pkg::VAL_W-1:0]         o_wr_value,
    output logic [$clog2(MAX_ITEMS)-1:0]      o_wr_idx,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    o_wr_cnt,
    output logic [$clog2(MAX_ITEMS)-1:0]      o_peak_idx,
    output logic [rcs_pkg::VAL_W-1:0]         o_peak_value,
    output logic                              o_done
);
    import rcs_pkg::*;

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [VAL_W-1:0] r_mem [MAX_ITEMS];
    logic [VAL_W-1:0] r_da;
    logic [VAL_W-1:0] r_db;

    logic          r_run;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic          r_s_valid;
    logic [IW-1:0] r_s_i;
    logic [IW-1:0] r_s_j;
    logic          r_s_last;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_peak_cnt;
    logic [IW-1:0] r_peak_idx;
    logic [VAL_W-1:0] r_peak_val;

    logic [IW-1:0] last;
    logic          ge;
    logic          b_first;
    logic [CW-1:0] cnt_tot;
    logic [CW-1:0] pos_tot;
    logic          row_end;

    always_ff @(posedge i_clk) begin
        if (i_load_we) begin
            r_mem[i_load_addr] <= i_load_data;
        end
        r_da <= r_mem[r_i];
        r_db <= r_mem[r_j];
    end

    always_comb begin
        last    = IW'(i_n - CW'(1));
        ge      = $signed(r_da) >= $signed(r_db);
        // b sorts ahead of a: smaller, or equal with a lower load position
        b_first = ($signed(r_db) < $signed(r_da)) || ((r_da == r_db) && (r_s_j < r_s_i));
        cnt_tot = ((r_s_j == '0) ? '0 : r_cnt) + CW'(ge);
        pos_tot = ((r_s_j == '0) ? '0 : r_pos) + CW'(b_first);
        row_end = r_s_valid && r_s_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_s_valid <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
        end else begin
            r_s_valid <= r_run;
            r_s_i     <= r_i;
            r_s_j     <= r_j;
            r_s_last  <= (r_j == last);
            if (i_ctl.scan_start) begin
                r_run <= 1'b1;
                r_i   <= '0;
                r_j   <= '0;
            end else if (r_run) begin
                if (r_j == last) begin
                    r_j <= '0;
                    if (r_i == last) begin
                        r_run <= 1'b0;
                    end else begin
                        r_i <= r_i + IW'(1);
                    end
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_valid) begin
            r_cnt <= cnt_tot;
            r_pos <= pos_tot;
        end
        // first position with the greatest count wins
        if (row_end && ((r_s_i == '0) || (cnt_tot > r_peak_cnt))) begin
            r_peak_cnt <= cnt_tot;
            r_peak_idx <= r_s_i;
            r_peak_val <= r_da;
        end
    end

    assign o_wr_valid   = row_end;
    assign o_wr_addr    = pos_tot[IW-1:0];
    assign o_wr_value   = r_da;
    assign o_wr_idx     = r_s_i;
    assign o_wr_cnt     = cnt_tot;
    assign o_peak_idx   = r_peak_idx;
    assign o_peak_value = r_peak_val;
    assign o_done       = row_end && (r_s_i == last);

endmodule

FILE: rtl/rcs_result_store.sv
`timescale 1ns / 1ps
// rcs_result_store: sorted record memory, read-out sequencing and output register
module rcs_result_store #(
    parameter int MAX_ITEMS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rcs_pkg::t_seq_ctl                     i_ctl,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]        i_n,
    input  logic                                  i_wr_valid,
    input  logic [$clog2(MAX_ITEMS)-1:0]          i_wr_addr,
    input  logic [rcs_pkg::VAL_W-1:0]             i_wr_value,
    input  logic [$clog2(MAX_ITEMS)-1:0]          i_wr_idx,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]        i_wr_cnt,
    input  logic [$clog2(MAX_ITEMS)-1:0]          i_peak_idx,
    input  logic [rcs_pkg::VAL_W-1:0]             i_peak_value,
    output logic                                  o_done,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [rcs_pkg::VAL_W-1:0]      o_sorted_value,
    output logic [rcs_pkg::IDX_OUT_W-1:0]         o_source_index,
    output logic [rcs_pkg::CNT_OUT_W-1:0]         o_rank_count,
    output logic [rcs_pkg::IDX_OUT_W-1:0]         o_peak_index,
    output logic signed [rcs_pkg::VAL_W-1:0]      o_peak_value,
    output logic                                  o_run_end
);
    import rcs_pkg::*;

    localparam int IW    = $clog2(MAX_ITEMS);
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int REC_W = VAL_W + IW + CW;

    logic [REC_W-1:0] r_mem [MAX_ITEMS];
    logic [REC_W-1:0] r_rd;

    logic          r_pend;
    logic          r_pend_last;
    logic [IW-1:0] r_k;
    logic          r_out_valid;

    logic [IW-1:0] last;
    logic          issue;

    always_comb begin
        last  = IW'(i_n - CW'(1));
        // read only when the output register is free by the time the data lands
        issue = i_ctl.emit_en && !r_pend && (!r_out_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_valid) begin
            r_mem[i_wr_addr] <= {i_wr_value, i_wr_idx, i_wr_cnt};
        end
        r_rd <= r_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (issue) begin
                r_pend      <= 1'b1;
                r_pend_last <= (r_k == last);
                r_k         <= (r_k == last) ? '0 : r_k + IW'(1);
            end else begin
                r_pend <= 1'b0;
            end
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            o_sorted_value <= r_rd[REC_W-1 -: VAL_W];
            o_source_index <= IDX_OUT_W'(r_rd[CW +: IW]);
            o_rank_count   <= CNT_OUT_W'(r_rd[CW-1:0]);
            o_peak_index   <= IDX_OUT_W'(i_peak_idx);
            o_peak_value   <= i_peak_value;
            o_run_end      <= r_pend_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_done  = issue && (r_k == last);

endmodule

FILE: rtl/rank_count_sorter.sv
`timescale 1ns / 1ps
// rank_count_sorter: top level, load sequencer tying the scan engine to the result store
// loading: one item per cycle while the input is not stalled, no result until the item that closes the set
// after the closing item: all n*n pairs scanned through one comparator on two value ports
// read-out: results from the sorted record memory, each fetch issued only after the last one landed, slower under stall
// input stalls from the closing item until the last record is fetched from the result memory
// reset clears sequencer and handshake state; the stores keep stale contents
module rank_count_sorter #(
    parameter int MAX_ITEMS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [rcs_pkg::VAL_W-1:0]      i_sample_value,
    input  logic                                  i_final_item,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [rcs_pkg::VAL_W-1:0]      o_sorted_value,
    output logic [rcs_pkg::IDX_OUT_W-1:0]         o_source_index,
    output logic [rcs_pkg::CNT_OUT_W-1:0]         o_rank_count,
    output logic [rcs_pkg::IDX_OUT_W-1:0]         o_peak_index,
    output logic signed [rcs_pkg::VAL_W-1:0]      o_peak_value,
    output logic                                  o_run_end
);
    import rcs_pkg::*;

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_n;
    logic [CW-1:0] n_n;

    t_seq_ctl      ctl;
    logic          accept;
    logic          load_we;
    logic          scan_done;
    logic          emit_done;

    logic             wr_valid;
    logic [IW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_value;
    logic [IW-1:0]    wr_idx;
    logic [CW-1:0]    wr_cnt;
    logic [IW-1:0]    peak_idx;
    logic [VAL_W-1:0] peak_value;

    assign o_stall = (r_state != ST_LOAD);
    assign accept  = i_valid && !o_stall;
    assign load_we = accept && (r_n < CW'(MAX_ITEMS));

    always_comb begin
        n_state        = r_state;
        n_n            = r_n;
        ctl.scan_start = 1'b0;
        ctl.emit_en    = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (load_we) begin
                    n_n = r_n + CW'(1);
                end
                if (accept && i_final_item) begin
                    ctl.scan_start = 1'b1;
                    n_state        = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                ctl.emit_en = 1'b1;
                if (emit_done) begin
                    n_n     = '0;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
        end
    end

    rcs_rank_engine #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_n          (r_n),
        .i_load_we    (load_we),
        .i_load_addr  (r_n[IW-1:0]),
        .i_load_data  (i_sample_value),
        .o_wr_valid   (wr_valid),
        .o_wr_addr    (wr_addr),
        .o_wr_value   (wr_value),
        .o_wr_idx     (wr_idx),
        .o_wr_cnt     (wr_cnt),
        .o_peak_idx   (peak_idx),
        .o_peak_value (peak_value),
        .o_done       (scan_done)
    );

    rcs_result_store #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_results (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_n            (r_n),
        .i_wr_valid     (wr_valid),
        .i_wr_addr      (wr_addr),
        .i_wr_value     (wr_value),
        .i_wr_idx       (wr_idx),
        .i_wr_cnt       (wr_cnt),
        .i_peak_idx     (peak_idx),
        .i_peak_value   (peak_value),
        .o_done         (emit_done),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_source_index (o_source_index),
        .o_rank_count   (o_rank_count),
        .o_peak_index   (o_peak_index),
        .o_peak_value   (o_peak_value),
        .o_run_end      (o_run_end)
    );

endmodule

FILE: rtl/rcs_checker.sv
`timescale 1ns / 1ps
// rcs_checker: port-level assertions for the rank count sorter, bound to the top level
module rcs_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_stall,
    input logic                                  i_final_item,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic signed [rcs_pkg::VAL_W-1:0]      o_sorted_value,
    input logic [rcs_pkg::IDX_OUT_W-1:0]         o_source_index,
    input logic [rcs_pkg::CNT_OUT_W-1:0]         o_rank_count,
    input logic signed [rcs_pkg::VAL_W-1:0]      o_peak_value,
    input logic                                  o_run_end
);
    import rcs_pkg::*;

    // a stalled result transaction holds its value, source index, rank count and end flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sorted_value) && $stable(o_source_index)
            && $stable(o_rank_count) && $stable(o_run_end))
        else $error("stalled result changed");

    // the closing item starts the scan, so input must stall right after
    a_busy_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_final_item |=> o_stall)
        else $error("input not stalled after closing item");

    // peak is the set maximum, never below any emitted value
    a_peak_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $signed(o_peak_value) >= $signed(o_sorted_value))
        else $error("peak value below sorted value");

    // after the last result of a set, a new set cannot show up at once
    a_gap_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_run_end && !i_stall |=> !o_valid)
        else $error("result right after end of set");

endmodule

bind rank_count_sorter rcs_checker u_rcs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_final_item   (i_final_item),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_sorted_value (o_sorted_value),
    .o_source_index (o_source_index),
    .o_rank_count   (o_rank_count),
    .o_peak_value   (o_peak_value),
    .o_run_end      (o_run_end)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: randomized self-checking bench for the rank count sorter
module testbench;
    import rcs_pkg::*;

    localparam int STORE_DEPTH = 16;

    typedef struct {
        logic signed [VAL_W-1:0]     value;
        logic [IDX_OUT_W-1:0]        src;
        logic [CNT_OUT_W-1:0]        rank;
        logic [IDX_OUT_W-1:0]        peak_idx;
        logic signed [VAL_W-1:0]     peak_val;
        logic                        last;
    } t_sorted_entry;

    typedef enum int {
        MIX_WIDE,
        MIX_NARROW,
        MIX_EDGE
    } t_value_mix;

    class t_rank_sort_board;
        logic signed [VAL_W-1:0] held[$];
        t_sorted_entry           sorted_q[$];
        int                      errors = 0;

        // mirrors the load, then ranks the whole set when the closing transaction lands
        function void note_sample(logic signed [VAL_W-1:0] v, logic last);
            t_sorted_entry e;
            int            cnt[STORE_DEPTH];
            int            n;
            int            peak;
            int            emitted;
            if (held.size() < STORE_DEPTH) begin
                held.insert(held.size(), v);
            end
            if (!last) begin
                return;
            end
            n = held.size();
            for (int i = 0; i < n; i++) begin
                cnt[i] = 0;
                for (int j = 0; j < n; j++) begin
                    if (held[i] >= held[j]) begin
                        cnt[i]++;
                    end
                end
            end
            peak = 0;
            for (int i = 1; i < n; i++) begin
                if (cnt[i] > cnt[peak]) begin
                    peak = i;
                end
            end
            // walking counts upward, indexes upward, gives lower index first on ties
            emitted = 0;
            for (int c = 1; c <= n; c++) begin
                for (int i = 0; i < n; i++) begin
                    if (cnt[i] == c) begin
                        e.value    = held[i];
                        e.src      = IDX_OUT_W'(i);
                        e.rank     = CNT_OUT_W'(c);
                        e.peak_idx = IDX_OUT_W'(peak);
                        e.peak_val = held[peak];
                        e.last     = (emitted == n - 1);
                        sorted_q.insert(sorted_q.size(), e);
                        emitted++;
                    end
                end
            end
            held.delete();
        endfunction

        function void check_result(t_sorted_entry got);
            t_sorted_entry want;
            if (sorted_q.size() == 0) begin
                $error("unexpected result transaction, value %0d index %0d",
                       got.value, got.src);
                errors++;
                return;
            end
            want = sorted_q.pop_front();
            if (got.value !== want.value) begin
                $error("sorted_value expected %0d got %0d", want.value, got.value);
                errors++;
            end
            if (got.src !== want.src) begin
                $error("source_index expected %0d got %0d", want.src, got.src);
                errors++;
            end
            if (got.rank !== want.rank) begin
                $error("rank_count expected %0d got %0d", want.rank, got.rank);
                errors++;
            end
            if (got.peak_idx !== want.peak_idx) begin
                $error("peak_index expected %0d got %0d", want.peak_idx, got.peak_idx);
                errors++;
            end
            if (got.peak_val !== want.peak_val) begin
                $error("peak_value expected %0d got %0d", want.peak_val, got.peak_val);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("run_end expected %0d got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction
    endclass

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_valid        = 1'b0;
    logic                          o_stall;
    logic signed [VAL_W-1:0]       i_sample_value = '0;
    logic                          i_final_item   = 1'b0;
    logic                          o_valid;
    logic                          i_stall        = 1'b0;
    logic signed [VAL_W-1:0]       o_sorted_value;
    logic [IDX_OUT_W-1:0]          o_source_index;
    logic [CNT_OUT_W-1:0]          o_rank_count;
    logic [IDX_OUT_W-1:0]          o_peak_index;
    logic signed [VAL_W-1:0]       o_peak_value;
    logic                          o_run_end;

    t_rank_sort_board board = new();
    bit src_idle_on      = 1'b1;
    bit sink_idle_on     = 1'b1;
    bit stall_burst_req  = 1'b0;
    int stored_total     = 0;

    rank_count_sorter #(
        .MAX_ITEMS(STORE_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_value (i_sample_value),
        .i_final_item   (i_final_item),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_source_index (o_source_index),
        .o_rank_count   (o_rank_count),
        .o_peak_index   (o_peak_index),
        .o_peak_value   (o_peak_value),
        .o_run_end      (o_run_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_sorted_entry got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                board.note_sample(i_sample_value, i_final_item);
            end
            if (o_valid && !i_stall) begin
                got.value    = o_sorted_value;
                got.src      = o_source_index;
                got.rank     = o_rank_count;
                got.peak_idx = o_peak_index;
                got.peak_val = o_peak_value;
                got.last     = o_run_end;
                board.check_result(got);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial begin : sink_driver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_burst_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (sink_idle_on) begin
                i_stall <= ($urandom_range(99) < 33);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value(t_value_mix mix);
        int t;
        case (mix)
            MIX_WIDE: begin
                return VAL_W'($urandom);
            end
            MIX_NARROW: begin
                t = $urandom_range(6);
                return VAL_W'(t - 3);
            end
            default: begin
                case ($urandom_range(4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return '0;
                    3:       return '1;
                    default: return VAL_W'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic send_sample(input logic signed [VAL_W-1:0] v, input logic last);
        bit taken;
        while (src_idle_on && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_value <= v;
        i_final_item   <= last;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_stall;
        end
        @(negedge i_clk);
    endtask

    task automatic send_set(input int n_items, input t_value_mix mix);
        for (int k = 0; k < n_items; k++) begin
            send_sample(pick_value(mix), k == n_items - 1);
        end
        stored_total += (n_items < STORE_DEPTH) ? n_items : STORE_DEPTH;
    endtask

    initial begin : stimulus
        int         set_len;
        int         roll;
        t_value_mix mix;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single-value set
        send_sample(16'sh7FFF, 1'b1);
        // both extremes, zero and minus one
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shFFFF, 1'b1);
        // tied maximum: peak must be the first copy
        send_sample(16'sd7, 1'b0);
        send_sample(-16'sd2, 1'b0);
        send_sample(16'sd7, 1'b1);
        // full store, closing transaction arrives past the end: it closes the set but its value is dropped
        for (int k = 0; k < STORE_DEPTH + 1; k++) begin
            send_sample(VAL_W'((k % 6) * 13107 - 32768), k == STORE_DEPTH);
        end

        stall_burst_req = 1'b1;
        while (stored_total < 450) begin
            src_idle_on  = !(stored_total >= 150 && stored_total < 250);
            sink_idle_on = src_idle_on;
            roll = $urandom_range(99);
            if (roll < 60) begin
                set_len = $urandom_range(6, 1);
            end else if (roll < 85) begin
                set_len = $urandom_range(15, 7);
            end else if (roll < 95) begin
                set_len = STORE_DEPTH;
            end else begin
                set_len = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH + 1);
            end
            mix = t_value_mix'($urandom_range(2));
            send_set(set_len, mix);
        end
        i_valid <= 1'b0;

        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (300) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
